// ===== rtl/core/brrc_pkg.sv =====
// shared types, codes and helpers for the random replacement cache
// no dependencies
`default_nettype none
package brrc_pkg;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 64;
	// word number of a byte address: address without its three byte bits
	localparam int WORD_W = ADDR_W - 3;

	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_BLOCK_WORDS = 8;
	localparam int DEF_ADDR_BITS   = 32;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	localparam logic [1:0] KIND_CPU   = 2'd0;
	localparam logic [1:0] KIND_BLKRD = 2'd1;
	localparam logic [1:0] KIND_WB    = 2'd2;
	localparam logic [1:0] KIND_REJ   = 2'd3;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

	function automatic logic [DATA_W-1:0] lane_mask(input logic [7:0] be);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = {8{be[b]}};
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/brrc_addr_div.sv =====
// splits a word number into block number and word offset
// uses brrc_pkg; registered shift for power-of-two blocks, else reciprocal multiply, estimate and correction stages
`default_nettype none
module brrc_addr_div #(
	parameter int BLOCK_WORDS = brrc_pkg::DEF_BLOCK_WORDS,
	parameter int TAG_W       = 26
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [brrc_pkg::WORD_W-1:0] dividend,
	output logic                             done,
	output logic [TAG_W-1:0]                 quot,
	output logic [$clog2(BLOCK_WORDS)-1:0]   rem
);
	import brrc_pkg::*;

	localparam int WB    = $clog2(BLOCK_WORDS);
	localparam bit POW2  = (BLOCK_WORDS & (BLOCK_WORDS - 1)) == 0;

	generate
		if (POW2) begin : g_shift
			logic             done_q;
			logic [TAG_W-1:0] quot_q;
			logic [WB-1:0]    rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					quot_q <= TAG_W'(dividend >> WB);
					rem_q  <= dividend[WB-1:0];
				end
			end

			assign done = done_q;
			assign quot = quot_q;
			assign rem  = rem_q;
		end else begin : g_recip
			// reciprocal estimate is low by at most one, one compare and subtract fixes it
			localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BLOCK_WORDS));
			localparam int PW = WORD_W + 32;

			logic              v_s1;
			logic              v_s2;
			logic              done_q;
			logic [WORD_W-1:0] n_s1;
			logic [PW-1:0]     prod_s1;
			logic [WORD_W-1:0] q_s2;
			logic [6:0]        r_s2;
			logic [TAG_W-1:0]  quot_q;
			logic [WB-1:0]     rem_q;
			logic [WORD_W-1:0] q_est;
			logic [WORD_W-1:0] r_est;
			logic              ge;

			always_comb begin
				q_est = prod_s1[PW-1:32];
				r_est = n_s1 - WORD_W'(q_est * WORD_W'(BLOCK_WORDS));
				ge    = r_s2 >= 7'(BLOCK_WORDS);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					n_s1    <= dividend;
					prod_s1 <= PW'(dividend) * PW'(RECIP);
				end
				if (v_s1) begin
					q_s2 <= q_est;
					r_s2 <= 7'(r_est);
				end
				if (v_s2) begin
					quot_q <= ge ? TAG_W'(q_s2 + 1'b1) : TAG_W'(q_s2);
					rem_q  <= ge ? WB'(r_s2 - 7'(BLOCK_WORDS)) : WB'(r_s2);
				end
			end

			assign done = done_q;
			assign quot = quot_q;
			assign rem  = rem_q;
		end
	endgenerate

endmodule
`default_nettype wire

// ===== rtl/core/brrc_tag_unit.sv =====
// tag memory, entry valid bits and the shared tag comparator
// uses brrc_pkg for the memory control struct
`default_nettype none
module brrc_tag_unit #(
	parameter int CAPACITY = brrc_pkg::DEF_CAPACITY,
	parameter int TAG_W    = 26
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire brrc_pkg::mem_ctl_t          ctl,
	input  wire logic [$clog2(CAPACITY)-1:0] idx,
	input  wire logic [TAG_W-1:0]            wtag,
	input  wire logic [TAG_W-1:0]            ref_tag,
	output logic [TAG_W-1:0]                 tag_q,
	output logic                             match,
	output logic [CAPACITY-1:0]              valid_vec
);
	import brrc_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic [TAG_W-1:0]    tag_mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [IW-1:0]       idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			tag_mem[idx] <= wtag;
		end
		if (ctl.rd) begin
			tag_q <= tag_mem[idx];
			idx_q <= idx;
		end
	end

	// an invalid entry never matches, whatever its tag word holds
	assign match     = valid_q[idx_q] && (tag_q == ref_tag);
	assign valid_vec = valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/brrc_data_ram.sv =====
// block data memory, one write and one registered read per cycle
// uses brrc_pkg for word width and the memory control struct
`default_nettype none
module brrc_data_ram #(
	parameter int DEPTH = brrc_pkg::DEF_CAPACITY * brrc_pkg::DEF_BLOCK_WORDS
) (
	input  wire logic                        clk,
	input  wire brrc_pkg::mem_ctl_t          ctl,
	input  wire logic [$clog2(DEPTH)-1:0]    addr,
	input  wire logic [brrc_pkg::DATA_W-1:0] wdata,
	output logic [brrc_pkg::DATA_W-1:0]      rdata_q
);
	import brrc_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/blocking_random_replacement_cache_unit.sv =====
// hit: address division, then the tag scan (one compare per cycle) up to the first match;
//   the division is a reciprocal multiply when BLOCK_WORDS is not a power of two
// miss: same scan, then the block read word; final fill word: free-entry search over the
//   entries, writeback of the victim word by word when all are valid, install, then the answer
// one word at a time; arst_n clears valid bits and control at once, no clearing pass
`default_nettype none
module blocking_random_replacement_cache_unit #(
	parameter int CAPACITY    = brrc_pkg::DEF_CAPACITY,
	parameter int BLOCK_WORDS = brrc_pkg::DEF_BLOCK_WORDS,
	parameter int ADDR_BITS   = brrc_pkg::DEF_ADDR_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  operation,
	input  wire logic [brrc_pkg::ADDR_W-1:0] address,
	input  wire logic [7:0]                  byte_enable,
	input  wire logic [brrc_pkg::DATA_W-1:0] write_data,
	input  wire logic [brrc_pkg::DATA_W-1:0] fill_data,
	input  wire logic                        fill_last,
	input  wire logic [3:0]                  victim_pick,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       response_kind,
	output logic                             hit,
	output logic [brrc_pkg::ADDR_W-1:0]      out_address,
	output logic [brrc_pkg::DATA_W-1:0]      read_data,
	output logic                             run_last
);
	import brrc_pkg::*;

	localparam int IW    = $clog2(CAPACITY);
	localparam int WB    = $clog2(BLOCK_WORDS);
	localparam int FC_W  = $clog2(BLOCK_WORDS + 1);
	localparam int TAG_W = 30 - $clog2(BLOCK_WORDS + 1);
	localparam int DEPTH = CAPACITY * BLOCK_WORDS;
	localparam int DA_W  = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] AMASK =
		(ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DIV    = 11'b00000000010,
		S_SCAN   = 11'b00000000100,
		S_MISS   = 11'b00000001000,
		S_FIND   = 11'b00000010000,
		S_WBTAG  = 11'b00000100000,
		S_WBRD   = 11'b00001000000,
		S_WBOUT  = 11'b00010000000,
		S_INST   = 11'b00100000000,
		S_ACCRD  = 11'b01000000000,
		S_ACCOUT = 11'b10000000000
	} state_t;

	state_t state_q;

	logic              busy_q;
	logic [FC_W-1:0]   fc_q;
	logic [DATA_W-1:0] fbuf_q [BLOCK_WORDS];

	logic              pwrite_q;
	logic [ADDR_W-1:0] paddr_q;
	logic [7:0]        pbe_q;
	logic [DATA_W-1:0] pdata_q;
	logic [TAG_W-1:0]  ptag_q;
	logic [WB-1:0]     pwoff_q;
	logic [3:0]        pick_q;
	logic              hit_r_q;

	logic [IW:0]       scan_q;
	logic              scan_v_s1;
	logic [IW-1:0]     scan_idx_s1;
	logic [IW-1:0]     e_q;
	logic [WB-1:0]     w_q;

	logic              ov_q;
	logic [1:0]        kind_q;
	logic              hit_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [DATA_W-1:0] odata_q;
	logic              olast_q;

	logic              accept;
	logic              out_free;
	logic [ADDR_W-1:0] addr_m;
	logic              div_start;
	logic              div_done;
	logic [TAG_W-1:0]  div_quot;
	logic [WB-1:0]     div_rem;

	mem_ctl_t          tag_ctl;
	logic [IW-1:0]     tag_idx;
	logic [TAG_W-1:0]  tag_rd;
	logic              tag_match;
	logic [CAPACITY-1:0] valid_vec;

	mem_ctl_t          ram_ctl;
	logic [WB-1:0]     ram_word;
	logic [DA_W-1:0]   ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] pmask;

	logic              emit;
	logic [1:0]        emit_kind;

	function automatic logic [ADDR_W-1:0] blk_of(input logic [TAG_W-1:0] t);
		return ADDR_W'(32'(t) * 32'(BLOCK_WORDS * 8));
	endfunction

	function automatic logic [IW-1:0] pick_mod(input logic [3:0] p);
		logic [8:0] v;
		v = {5'd0, p};
		for (int i = 0; i < 8; i++) begin
			if (v >= 9'(CAPACITY)) begin
				v = v - 9'(CAPACITY);
			end
		end
		return IW'(v);
	endfunction

	assign out_free  = !ov_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign accept    = in_valid && !in_stall;
	assign addr_m    = address & AMASK;
	assign div_start = accept && !busy_q && (operation == OP_READ || operation == OP_WRITE);
	assign pmask     = lane_mask(pbe_q);

	brrc_addr_div #(
		.BLOCK_WORDS(BLOCK_WORDS),
		.TAG_W      (TAG_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(addr_m[ADDR_W-1:3]),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	brrc_tag_unit #(
		.CAPACITY(CAPACITY),
		.TAG_W   (TAG_W)
	) u_tag (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tag_ctl),
		.idx      (tag_idx),
		.wtag     (ptag_q),
		.ref_tag  (ptag_q),
		.tag_q    (tag_rd),
		.match    (tag_match),
		.valid_vec(valid_vec)
	);

	brrc_data_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.ctl    (ram_ctl),
		.addr   (ram_addr),
		.wdata  (ram_wdata),
		.rdata_q(ram_rdata)
	);

	always_comb begin
		tag_ctl = '0;
		tag_idx = e_q;
		case (state_q)
			S_SCAN: begin
				tag_ctl.rd = scan_q < (IW + 1)'(CAPACITY);
				tag_idx    = scan_q[IW-1:0];
			end
			S_WBTAG: tag_ctl.rd = 1'b1;
			S_INST:  tag_ctl.wr = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		ram_ctl   = '0;
		ram_word  = w_q;
		ram_wdata = (pdata_q & pmask) | (ram_rdata & ~pmask);
		case (state_q)
			S_WBRD: ram_ctl.rd = 1'b1;
			S_INST: begin
				ram_ctl.wr = 1'b1;
				// words that the fill never delivered install as zero
				ram_wdata  = (FC_W'(w_q) < fc_q) ? fbuf_q[w_q] : '0;
			end
			S_ACCRD: begin
				ram_ctl.rd = 1'b1;
				ram_word   = pwoff_q;
			end
			S_ACCOUT: begin
				ram_ctl.wr = out_free && pwrite_q;
				ram_word   = pwoff_q;
			end
			default: ;
		endcase
		ram_addr = DA_W'(32'(e_q) * 32'(BLOCK_WORDS) + 32'(ram_word));
	end

	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_CPU;
		case (state_q)
			S_IDLE: begin
				emit      = accept && busy_q && (operation == OP_READ || operation == OP_WRITE);
				emit_kind = KIND_REJ;
			end
			S_MISS: begin
				emit      = out_free;
				emit_kind = KIND_BLKRD;
			end
			S_WBOUT: begin
				emit      = out_free;
				emit_kind = KIND_WB;
			end
			S_ACCOUT: emit = out_free;
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= emit_kind;
			case (state_q)
				S_IDLE: begin
					hit_q   <= 1'b0;
					oaddr_q <= addr_m;
					odata_q <= '0;
					olast_q <= 1'b1;
				end
				S_MISS: begin
					hit_q   <= 1'b0;
					oaddr_q <= blk_of(ptag_q);
					odata_q <= '0;
					olast_q <= 1'b1;
				end
				S_WBOUT: begin
					hit_q   <= 1'b0;
					oaddr_q <= blk_of(tag_rd);
					odata_q <= ram_rdata;
					olast_q <= 1'b0;
				end
				default: begin
					hit_q   <= hit_r_q;
					oaddr_q <= paddr_q;
					odata_q <= pwrite_q ? '0 : (ram_rdata & pmask);
					olast_q <= 1'b1;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			fc_q      <= '0;
			scan_q    <= '0;
			scan_v_s1 <= 1'b0;
			hit_r_q   <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == S_SCAN) && (scan_q < (IW + 1)'(CAPACITY));
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_READ, OP_WRITE: begin
								if (!busy_q) begin
									state_q <= S_DIV;
								end
							end
							OP_FILL: begin
								if (busy_q) begin
									if (fc_q < FC_W'(BLOCK_WORDS)) begin
										fc_q <= fc_q + 1'b1;
									end
									if (fill_last) begin
										scan_q  <= '0;
										state_q <= S_FIND;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q < (IW + 1)'(CAPACITY)) begin
						scan_q <= scan_q + 1'b1;
					end
					if (scan_v_s1 && tag_match) begin
						hit_r_q <= 1'b1;
						state_q <= S_ACCRD;
					end else if (scan_v_s1 && scan_idx_s1 == IW'(CAPACITY - 1)) begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (out_free) begin
						busy_q  <= 1'b1;
						fc_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					// lowest invalid entry first, the picked victim when all are valid
					if (!valid_vec[scan_q[IW-1:0]]) begin
						state_q <= S_INST;
					end else if (scan_q[IW-1:0] == IW'(CAPACITY - 1)) begin
						state_q <= S_WBTAG;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_WBTAG: state_q <= S_WBRD;
				S_WBRD:  state_q <= S_WBOUT;
				S_WBOUT: begin
					if (out_free) begin
						state_q <= (w_q == WB'(BLOCK_WORDS - 1)) ? S_INST : S_WBRD;
					end
				end
				S_INST: begin
					if (w_q == WB'(BLOCK_WORDS - 1)) begin
						hit_r_q <= 1'b0;
						state_q <= S_ACCRD;
					end
				end
				S_ACCRD: state_q <= S_ACCOUT;
				S_ACCOUT: begin
					if (out_free) begin
						busy_q  <= 1'b0;
						hit_r_q <= 1'b0;
						if (!hit_r_q) begin
							fc_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (div_start) begin
					pwrite_q <= (operation == OP_WRITE);
					paddr_q  <= addr_m;
					pbe_q    <= byte_enable;
					pdata_q  <= write_data;
				end
				if (accept && busy_q && operation == OP_FILL) begin
					if (fc_q < FC_W'(BLOCK_WORDS)) begin
						fbuf_q[fc_q[WB-1:0]] <= fill_data;
					end
					pick_q <= victim_pick;
				end
			end
			S_DIV: begin
				if (div_done) begin
					ptag_q  <= div_quot;
					pwoff_q <= div_rem;
				end
			end
			S_SCAN: begin
				if (scan_v_s1 && tag_match) begin
					e_q <= scan_idx_s1;
				end
			end
			S_FIND: begin
				w_q <= '0;
				if (!valid_vec[scan_q[IW-1:0]]) begin
					e_q <= scan_q[IW-1:0];
				end else if (scan_q[IW-1:0] == IW'(CAPACITY - 1)) begin
					e_q <= pick_mod(pick_q);
				end
			end
			S_WBOUT: begin
				if (out_free) begin
					w_q <= (w_q == WB'(BLOCK_WORDS - 1)) ? '0 : w_q + 1'b1;
				end
			end
			S_INST: w_q <= w_q + 1'b1;
			default: ;
		endcase
	end

	assign out_valid     = ov_q;
	assign response_kind = kind_q;
	assign hit           = hit_q;
	assign out_address   = oaddr_q;
	assign read_data     = odata_q;
	assign run_last      = olast_q;

	a_wb_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_kind == KIND_WB) |-> (&valid_vec))
		else $error("writeback while a free entry exists");

	a_nonlast_is_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !olast_q) |-> (kind_q == KIND_WB))
		else $error("non-final word that is not a writeback");

	a_hit_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == KIND_CPU && hit_q) |-> !busy_q)
		else $error("hit answered while a fill is pending");

	a_fill_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_W'(BLOCK_WORDS))
		else $error("fill count past block size");

	a_busy_blocks_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DIV) |-> !busy_q)
		else $error("lookup started during a pending fill");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the blocking random replacement cache: queue-fed driver, clocked monitor
// depends on brrc_pkg and blocking_random_replacement_cache_unit
`timescale 1ns / 1ps
module tb_top;
	import brrc_pkg::*;

	localparam int NENT = DEF_CAPACITY;
	localparam int NWRD = DEF_BLOCK_WORDS;
	localparam int LIMIT = 1000000;

	typedef struct {
		logic [1:0] op;
		logic [31:0] addr;
		logic [7:0] be;
		logic [63:0] wd;
		logic [63:0] fd;
		logic last;
		logic [3:0] pick;
	} word_t;

	typedef struct {
		logic [1:0] kind;
		logic h;
		logic [31:0] addr;
		logic [63:0] data;
		logic rl;
	} resp_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic in_stall, out_valid;
	logic [1:0] operation = 0;
	logic [31:0] address = 0;
	logic [7:0] byte_enable = 0;
	logic [63:0] write_data = 0, fill_data = 0;
	logic fill_last = 0;
	logic [3:0] victim_pick = 0;
	logic [1:0] response_kind;
	logic hit, run_last;
	logic [31:0] out_address;
	logic [63:0] read_data;

	blocking_random_replacement_cache_unit dut (.*);

	// predictor state
	bit m_valid [NENT];
	logic [25:0] m_tag [NENT];
	logic [63:0] m_data [NENT*NWRD];
	bit m_busy, m_pw;
	logic [31:0] m_pa;
	logic [7:0] m_pe;
	logic [63:0] m_pd;
	logic [63:0] m_fill [NWRD];
	int m_cnt;

	word_t pending_words[$];
	resp_t expected_resp[$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;
	bit hold = 0;
	int cycles = 0;

	function automatic logic [63:0] lanes(logic [7:0] be);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) if (be[b]) m[8*b +: 8] = 8'hff;
		return m;
	endfunction

	function automatic logic [63:0] access(int e, logic [31:0] a, bit wr,
			logic [7:0] be, logic [63:0] wd);
		int i;
		logic [63:0] m;
		i = e*NWRD + int'(a[5:3]);
		m = lanes(be);
		if (wr) begin
			m_data[i] = (m_data[i] & ~m) | (wd & m);
			return '0;
		end
		return m_data[i] & m;
	endfunction

	function automatic void push(logic [1:0] k, logic h, logic [31:0] a,
			logic [63:0] d, logic l);
		resp_t r;
		r.kind = k; r.h = h; r.addr = a; r.data = d; r.rl = l;
		expected_resp.push_back(r);
	endfunction

	function automatic void predict(word_t w);
		int e;
		logic [63:0] r;
		if (w.op == OP_READ || w.op == OP_WRITE) begin
			if (m_busy) begin
				push(KIND_REJ, 1'b0, w.addr, 64'd0, 1'b1);
				return;
			end
			for (e = 0; e < NENT; e++)
				if (m_valid[e] && m_tag[e] == w.addr[31:6]) begin
					r = access(e, w.addr, w.op == OP_WRITE, w.be, w.wd);
					push(KIND_CPU, 1'b1, w.addr, r, 1'b1);
					return;
				end
			m_busy = 1; m_pw = (w.op == OP_WRITE); m_pa = w.addr;
			m_pe = w.be; m_pd = w.wd; m_cnt = 0;
			for (int i = 0; i < NWRD; i++) m_fill[i] = 0;
			push(KIND_BLKRD, 1'b0, {w.addr[31:6], 6'd0}, 64'd0, 1'b1);
			return;
		end
		if (w.op != OP_FILL || !m_busy) return;
		if (m_cnt < NWRD) begin
			m_fill[m_cnt] = w.fd;
			m_cnt++;
		end
		if (!w.last) return;
		for (e = 0; e < NENT; e++) if (!m_valid[e]) break;
		if (e == NENT) begin
			e = int'(w.pick);
			for (int i = 0; i < NWRD; i++)
				push(KIND_WB, 1'b0, {m_tag[e], 6'd0}, m_data[e*NWRD+i], 1'b0);
		end
		m_valid[e] = 1;
		m_tag[e] = m_pa[31:6];
		for (int i = 0; i < NWRD; i++) m_data[e*NWRD+i] = m_fill[i];
		r = access(e, m_pa, m_pw, m_pe, m_pd);
		push(KIND_CPU, 1'b0, m_pa, r, 1'b1);
		m_busy = 0; m_cnt = 0;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	initial forever #4 clk = ~clk;

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict(pending_words.pop_front());
		end
		if (!in_valid || !in_stall) begin
			if (pending_words.size() > 0 && !hold && $urandom_range(99) >= send_idle) begin
				in_valid <= 1;
				operation <= pending_words[0].op;
				address <= pending_words[0].addr;
				byte_enable <= pending_words[0].be;
				write_data <= pending_words[0].wd;
				fill_data <= pending_words[0].fd;
				fill_last <= pending_words[0].last;
				victim_pick <= pending_words[0].pick;
			end else
				in_valid <= 0;
		end
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// monitor
	always @(posedge clk) begin
		resp_t x;
		cycles++;
		if (out_valid && !out_stall) begin
			if (expected_resp.size() == 0) begin
				report("unexpected word", 64'(response_kind), 64'd0);
			end else begin
				x = expected_resp.pop_front();
				if (response_kind !== x.kind)
					report("kind", 64'(response_kind), 64'(x.kind));
				if (hit !== x.h) report("hit", 64'(hit), 64'(x.h));
				if (out_address !== x.addr)
					report("address", 64'(out_address), 64'(x.addr));
				if (read_data !== x.data) report("data", read_data, x.data);
				if (run_last !== x.rl) report("run_last", 64'(run_last), 64'(x.rl));
			end
		end
		if (cycles > LIMIT) begin
			$display("FAIL blocking_random_replacement_cache_unit");
			$finish;
		end
	end

	function automatic word_t cpu(logic [1:0] op, logic [31:0] a);
		word_t w;
		w.op = op; w.addr = a; w.be = 8'($urandom); w.wd = {$urandom, $urandom};
		w.fd = {$urandom, $urandom}; w.last = 1'($urandom); w.pick = 4'($urandom);
		return w;
	endfunction

	function automatic word_t fillw(logic l);
		word_t w;
		w = cpu(OP_FILL, $urandom);
		w.last = l;
		return w;
	endfunction

	// one read or write with a fill run, plus an optional request that is rejected if the first missed
	function automatic void miss_seq(logic [31:0] a, int nw);
		pending_words.push_back(cpu(2'($urandom_range(1)), a));
		if ($urandom_range(3) == 0)
			pending_words.push_back(cpu(2'($urandom_range(1)), $urandom));
		for (int i = 0; i < nw - 1; i++) pending_words.push_back(fillw(1'b0));
		pending_words.push_back(fillw(1'b1));
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || expected_resp.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	logic [31:0] pool [24];
	word_t w;

	initial begin
		for (int i = 0; i < 24; i++) pool[i] = {$urandom} & ~32'h7 | ($urandom & 7);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed: fill while idle, extremes, short and long fills, reject
		pending_words.push_back(fillw(1'b1));
		w = cpu(OP_WRITE, 32'hffff_ffff); w.be = 8'hff; w.wd = '1;
		pending_words.push_back(w);
		pending_words.push_back(cpu(OP_READ, 32'h0));
		for (int i = 0; i < NWRD; i++) pending_words.push_back(fillw(i == NWRD-1));
		w = cpu(OP_READ, 32'hffff_fff8); w.be = 8'hff; pending_words.push_back(w);
		w = cpu(OP_WRITE, 32'h0); w.be = 8'h00; pending_words.push_back(w);
		miss_seq(32'h0000_1000, 2);
		miss_seq(32'h8000_0000, NWRD + 3);
		w = cpu(OP_READ, 32'h8000_0000); w.be = 8'hff; pending_words.push_back(w);
		drain();
		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 45 : 23) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 45 : 23) : 0;
			for (int n = 0; n < 5; n++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: pending_words.push_back(cpu(2'($urandom_range(1)),
						pool[$urandom_range(23)] ^ ($urandom & 32'h3f)));
					4, 5, 6: miss_seq(pool[$urandom_range(23)] ^ {2'($urandom_range(3)), 30'd0},
						$urandom_range(5) == 0 ? $urandom_range(1, NWRD+2) : NWRD);
					7: miss_seq($urandom, NWRD);
					8: pending_words.push_back(fillw(1'($urandom)));
					default: pending_words.push_back(cpu(OP_READ, $urandom));
				endcase
			end
			if (ph == 1) begin
				// wait until every expected word has arrived, then hold the driver off
				while (pending_words.size() > 0 || expected_resp.size() > 0) @(posedge clk);
				hold = 1;
				repeat (20) @(posedge clk);
				hold = 0;
			end
		end
		drain();
		if (errors == 0)
			$display("PASS blocking_random_replacement_cache_unit");
		else
			$display("FAIL blocking_random_replacement_cache_unit");
		$finish;
	end
endmodule
